/* sv/psmw_pkg.sv */
// Package with types and constants for the priority server max-wait block.
`default_nettype none

package psmw_pkg;

    localparam int MAX_JOBS = 1024;
    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int TIME_W = 48;
    localparam int FIELD_W = 32;
    localparam int ENTRY_W = 2 * FIELD_W + 1;

    typedef struct packed {
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] duration;
        logic               last;
    } job_t;

    typedef struct packed {
        logic [TIME_W-1:0] max_wait;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic               served;
        logic [FIELD_W-1:0] duration;
        logic [FIELD_W-1:0] arrival;
    } entry_t;

endpackage

`default_nettype wire

/* sv/priority_service_max_wait.sv */
// Top level of the non-preemptive priority server that reports the largest wait.
// Loading takes one transaction per cycle and never stalls while jobs are loaded.
// After the last job, each of the n service picks scans the job RAM once, one entry
// per cycle over its single read port, then goes through states UPD1 and UPD2.
// Reset clears control state only; the served mark of each entry is written at load.
`default_nettype none

module priority_service_max_wait
    import psmw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    job_valid,
    output logic         job_stall,
    input  wire job_t    job,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_UPD1   = 3'd2;
    localparam logic [2:0] ST_UPD2   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               overflow_reg, overflow_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [FIELD_W-1:0] hit_a_reg, hit_a_next;
    logic [FIELD_W-1:0] hit_d_reg, hit_d_next;
    logic               min_found_reg, min_found_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [FIELD_W-1:0] min_a_reg, min_a_next;
    logic [FIELD_W-1:0] min_d_reg, min_d_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [TIME_W-1:0]  worst_reg, worst_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  wait_reg, wait_next;
    logic               result_valid_reg, result_valid_next;
    result_t            result_reg, result_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             ram_rdata;

    logic               accept;
    logic [IDX_W-1:0]   pick_idx;
    logic [FIELD_W-1:0] pick_a;
    logic [FIELD_W-1:0] pick_d;
    logic [TIME_W:0]    diff;

    psmw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_JOBS)
    ) u_job_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign job_stall    = (state_reg != ST_LOAD);
    assign accept       = job_valid && !job_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign pick_idx = hit_found_reg ? hit_idx_reg : min_idx_reg;
    assign pick_a   = hit_found_reg ? hit_a_reg : min_a_reg;
    assign pick_d   = hit_found_reg ? hit_d_reg : min_d_reg;
    assign diff     = {1'b0, time_reg} - {{(TIME_W - FIELD_W + 1){1'b0}}, pick_a};
    assign ram_raddr = issue_reg[IDX_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        done_next         = done_reg;
        issue_next        = issue_reg;
        rd_valid_next     = 1'b0;
        rd_idx_next       = rd_idx_reg;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_a_next        = hit_a_reg;
        hit_d_next        = hit_d_reg;
        min_found_next    = min_found_reg;
        min_idx_next      = min_idx_reg;
        min_a_next        = min_a_reg;
        min_d_next        = min_d_reg;
        time_next         = time_reg;
        worst_next        = worst_reg;
        start_next        = start_reg;
        wait_next         = wait_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = count_reg[IDX_W-1:0];
        ram_wdata         = '{served: 1'b0, duration: job.duration, arrival: job.arrival};

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_JOBS))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (job.last)
                    begin
                        state_next     = ST_SCAN;
                        done_next      = '0;
                        issue_next     = '0;
                        hit_found_next = 1'b0;
                        min_found_next = 1'b0;
                        time_next      = '0;
                        worst_next     = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    issue_next    = issue_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                    rd_idx_next   = issue_reg[IDX_W-1:0];
                end
                if (rd_valid_reg && !ram_rdata.served)
                begin
                    if (!hit_found_reg &&
                        ({{(TIME_W - FIELD_W){1'b0}}, ram_rdata.arrival} <= time_reg))
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_a_next     = ram_rdata.arrival;
                        hit_d_next     = ram_rdata.duration;
                    end
                    if (!min_found_reg || (ram_rdata.arrival < min_a_reg))
                    begin
                        min_found_next = 1'b1;
                        min_idx_next   = rd_idx_reg;
                        min_a_next     = ram_rdata.arrival;
                        min_d_next     = ram_rdata.duration;
                    end
                end
                if ((issue_reg == count_reg) && !rd_valid_reg)
                begin
                    state_next = (hit_found_reg || min_found_reg) ? ST_UPD1 : ST_FINISH;
                end
            end
            ST_UPD1:
            begin
                if (diff[TIME_W])
                begin
                    start_next = {{(TIME_W - FIELD_W){1'b0}}, pick_a};
                    wait_next  = '0;
                end
                else
                begin
                    start_next = time_reg;
                    wait_next  = diff[TIME_W-1:0];
                end
                state_next = ST_UPD2;
            end
            ST_UPD2:
            begin
                if (wait_reg > worst_reg)
                begin
                    worst_next = wait_reg;
                end
                time_next  = start_reg + {{(TIME_W - FIELD_W){1'b0}}, pick_d};
                ram_we     = 1'b1;
                ram_waddr  = pick_idx;
                ram_wdata  = '{served: 1'b1, duration: pick_d, arrival: pick_a};
                done_next  = done_reg + CNT_W'(1);
                issue_next     = '0;
                hit_found_next = 1'b0;
                min_found_next = 1'b0;
                if ((done_reg + CNT_W'(1)) == count_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{max_wait: worst_reg, overflow: overflow_reg};
                    count_next        = '0;
                    overflow_next     = 1'b0;
                    state_next        = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            done_reg         <= '0;
            issue_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            hit_found_reg    <= 1'b0;
            min_found_reg    <= 1'b0;
            time_reg         <= '0;
            worst_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            done_reg         <= done_next;
            issue_reg        <= issue_next;
            rd_valid_reg     <= rd_valid_next;
            hit_found_reg    <= hit_found_next;
            min_found_reg    <= min_found_next;
            time_reg         <= time_next;
            worst_reg        <= worst_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_a_reg   <= hit_a_next;
        hit_d_reg   <= hit_d_next;
        min_idx_reg <= min_idx_next;
        min_a_reg   <= min_a_next;
        min_d_reg   <= min_d_next;
        start_reg   <= start_next;
        wait_reg    <= wait_next;
        result_reg  <= result_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS))
        else $error("Job count exceeds the store depth.");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == ST_FINISH))
        else $error("Result raised outside the finish step.");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SCAN))
        else $error("Read data returned outside a scan.");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD2) |-> (CNT_W'(pick_idx) < count_reg))
        else $error("Served mark written beyond the stored jobs.");

endmodule

`default_nettype wire

/* sv/psmw_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module psmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* dv/tb_priority_service_max_wait.sv */
// Testbench for the non-preemptive priority server that reports the largest wait.
`timescale 1ns / 100ps

module tb_priority_service_max_wait
    import psmw_pkg::*;
();

    localparam int HOLD_CYCLES = 800;
    localparam int WATCHDOG_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {MIX_DENSE, MIX_WIDE, MIX_CLUSTER, MIX_TOP} mix_e;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    job_valid = 1'b0;
    logic    job_stall;
    job_t    job = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic    hold_req = 1'b0;
    int      hold_left = 0;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;
    int      quiet_cycles = 0;

    logic [FIELD_W-1:0] set_arrivals [0:MAX_JOBS-1];
    logic [FIELD_W-1:0] set_durations [0:MAX_JOBS-1];
    int      set_count = 0;
    bit      set_overflow = 1'b0;
    result_t expected_results [$];

    int      jobs_accepted = 0;
    int      sets_closed = 0;
    int      results_checked = 0;
    int      error_count = 0;

    priority_service_max_wait u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_stall    (job_stall),
        .job          (job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #1 clk = ~clk;

    function automatic logic [TIME_W-1:0] predict_max_wait(input int n);
        bit          served [0:MAX_JOBS-1];
        logic [63:0] clock_now;
        logic [63:0] worst;
        logic [63:0] job_wait;
        int          pick;
        clock_now = '0;
        worst = '0;
        for (int i = 0; i < MAX_JOBS; i++)
            served[i] = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            pick = -1;
            for (int i = 0; i < n; i++)
                if (pick < 0 && !served[i] && set_arrivals[i] <= clock_now)
                    pick = i;
            if (pick < 0)
            begin
                for (int i = 0; i < n; i++)
                    if (!served[i] && (pick < 0 || set_arrivals[i] < set_arrivals[pick]))
                        pick = i;
            end
            if (set_arrivals[pick] > clock_now)
                clock_now = set_arrivals[pick];
            job_wait = clock_now - set_arrivals[pick];
            if (job_wait > worst)
                worst = job_wait;
            clock_now = clock_now + set_durations[pick];
            served[pick] = 1'b1;
        end
        return worst[TIME_W-1:0];
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && job_valid && !job_stall)
        begin
            jobs_accepted++;
            if (set_count < MAX_JOBS)
            begin
                set_arrivals[set_count] = job.arrival;
                set_durations[set_count] = job.duration;
                set_count++;
            end
            else
                set_overflow = 1'b1;
            if (job.last)
            begin
                want.max_wait = predict_max_wait(set_count);
                want.overflow = set_overflow;
                expected_results.push_back(want);
                set_count = 0;
                set_overflow = 1'b0;
                sets_closed++;
            end
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, max_wait %0d, overflow %0d",
                         $time, result.max_wait, result.overflow);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (result.max_wait !== want.max_wait)
                begin
                    error_count++;
                    $display("%0t: max_wait mismatch, expected %0d, actual %0d",
                             $time, want.max_wait, result.max_wait);
                end
                if (result.overflow !== want.overflow)
                begin
                    error_count++;
                    $display("%0t: overflow mismatch, expected %0d, actual %0d",
                             $time, want.overflow, result.overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req)
        begin
            result_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            result_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((job_valid && !job_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("priority_service_max_wait test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_job(input logic [FIELD_W-1:0] arr, input logic [FIELD_W-1:0] dur,
                            input logic fin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            job_valid <= 1'b0;
            @(posedge clk);
        end
        job_valid <= 1'b1;
        job <= '{arrival: arr, duration: dur, last: fin};
        @(posedge clk);
        while (job_stall)
            @(posedge clk);
    endtask

    task automatic send_set(input int n, input mix_e mix);
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] arr;
        logic [FIELD_W-1:0] dur;
        base = $urandom;
        for (int i = 0; i < n; i++)
        begin
            case (mix)
                MIX_DENSE:
                begin
                    arr = $urandom_range(200);
                    dur = $urandom_range(40);
                end
                MIX_WIDE:
                begin
                    arr = $urandom;
                    dur = $urandom;
                end
                MIX_CLUSTER:
                begin
                    arr = base + $urandom_range(1000);
                    dur = $urandom_range(300);
                end
                default:
                begin
                    arr = 32'hFFFF_FFFF - $urandom_range(50);
                    dur = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom_range(20);
                end
            endcase
            send_job(arr, dur, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        job_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic test_lone_jobs();
        send_job(32'h0, 32'h0, 1'b1);
        send_job(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_job(32'h0, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_index_priority();
        send_job(32'd5, 32'd10, 1'b0);
        send_job(32'd5, 32'd20, 1'b0);
        send_job(32'd5, 32'd30, 1'b1);
        send_job(32'd0, 32'd100, 1'b0);
        send_job(32'd50, 32'd1, 1'b0);
        send_job(32'd10, 32'd1, 1'b1);
    endtask

    task automatic test_idle_jump();
        send_job(32'd100, 32'd5, 1'b0);
        send_job(32'd40, 32'd5, 1'b0);
        send_job(32'd40, 32'd5, 1'b0);
        send_job(32'd200, 32'd0, 1'b0);
        send_job(32'd150, 32'd80, 1'b1);
    endtask

    task automatic test_wide_values();
        send_job(32'h0, 32'hFFFF_FFFF, 1'b0);
        send_job(32'h0, 32'hFFFF_FFFF, 1'b0);
        send_job(32'h0, 32'hFFFF_FFFF, 1'b0);
        send_job(32'hFFFF_FFFF, 32'h0, 1'b0);
        send_job(32'h1, 32'hAAAA_5555, 1'b1);
    endtask

    task automatic test_random_sets(input int target);
        int sent;
        int n;
        sent = 0;
        while (sent < target)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            send_set(n, mix_e'($urandom_range(3)));
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 4; i++)
            send_set(3, MIX_DENSE);
    endtask

    task automatic test_overflow();
        send_set(MAX_JOBS + 3, MIX_DENSE);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 7;
        sink_idle_pct = 66;
        test_lone_jobs();
        test_index_priority();
        test_idle_jump();
        test_wide_values();
        test_random_sets(180);
        wait_drained();

        src_idle_pct = 66;
        sink_idle_pct = 7;
        test_random_sets(180);
        wait_drained();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_backpressure();
        test_random_sets(160);
        test_overflow();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d job transactions in %0d sets, one of them past capacity,",
                 jobs_accepted, sets_closed);
        $display("with %0d results checked and %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("priority_service_max_wait test passed");
        else
            $display("priority_service_max_wait test failed");
        $finish;
    end

endmodule
